// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks (the top level).
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/twvc_pkg.sv =====
// Shared types, constants and decode functions for the display-width counter.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package twvc_pkg;

    // Running count width
    localparam int COUNT_BITS = 16;
    localparam int COUNT_W1   = COUNT_BITS + 1;
    localparam int NUM_WIDE   = 27;

    // Escape handling bytes
    localparam logic [7:0] BYTE_ESC = 8'h1B;
    localparam logic [7:0] BYTE_M   = 8'h6D;
    localparam logic [7:0] BYTE_BSL = 8'h5C;
    localparam logic [7:0] BYTE_BEL = 8'h07;

    // East Asian wide ranges, inclusive
    localparam logic [20:0] WIDE_LO [NUM_WIDE] = '{
        21'h01100, 21'h02329, 21'h02E80, 21'h02F00, 21'h02FF0, 21'h03000, 21'h03041,
        21'h03099, 21'h03105, 21'h03131, 21'h03190, 21'h031C0, 21'h031F0, 21'h03200,
        21'h03300, 21'h03400, 21'h04E00, 21'h0A000, 21'h0A490, 21'h0AC00, 21'h0F900,
        21'h0FE10, 21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h20000, 21'h30000
    };
    localparam logic [20:0] WIDE_HI [NUM_WIDE] = '{
        21'h0115F, 21'h0232A, 21'h02EFF, 21'h02FDF, 21'h02FFF, 21'h0303E, 21'h03096,
        21'h030FF, 21'h0312F, 21'h0318E, 21'h031BF, 21'h031EF, 21'h031FF, 21'h032FF,
        21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0A48F, 21'h0A4CF, 21'h0D7A3, 21'h0FAFF,
        21'h0FE19, 21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h2FFFD, 21'h3FFFD
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] display_width;
        logic        width_saturated;
    } t_out_beat;

    // Decoder state
    typedef struct packed {
        logic        esc;
        logic [1:0]  pend;
        logic [1:0]  seqlen;
        logic [20:0] cp;
    } t_dec_state;

    // Result of consuming one byte
    typedef struct packed {
        t_dec_state st;
        logic [1:0] add;
        logic       held_we;
        logic       held_idx;
    } t_step_res;

    // Snapshot handed to the end-of-string stage
    typedef struct packed {
        t_dec_state            st;
        logic [7:0]            held0;
        logic [7:0]            held1;
        logic [COUNT_BITS-1:0] count;
    } t_tail_beat;

    // Columns for one decoded codepoint
    function automatic logic [1:0] cp_width(logic [20:0] cp);
        logic wide;
        wide = 1'b0;
        for (int i = 0; i < NUM_WIDE; i++) begin
            if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
                wide = 1'b1;
            end
        end
        if (cp == 21'd0) begin
            return 2'd0;
        end
        return wide ? 2'd2 : 2'd1;
    endfunction

    // One byte through the escape / UTF-8 decoder
    function automatic t_step_res dec_consume(t_dec_state s, logic [7:0] b);
        t_step_res   r;
        logic [1:0]  idx;
        logic [20:0] cp_next;
        r          = '0;
        r.st       = s;
        idx        = s.seqlen - s.pend;
        r.held_idx = idx[0];
        cp_next    = {s.cp[14:0], b[5:0]};
        if (s.pend != 2'd0) begin
            // continuation byte, tag bits ignored
            r.held_we   = !idx[1];
            r.st.cp     = cp_next;
            r.st.pend   = s.pend - 2'd1;
            if (s.pend == 2'd1) begin
                r.add       = cp_width(cp_next);
                r.st.seqlen = 2'd0;
                r.st.cp     = '0;
            end
        end else if (s.esc) begin
            if (b == BYTE_M || b == BYTE_BSL || b == BYTE_BEL) begin
                r.st.esc = 1'b0;
            end
        end else if (b == BYTE_ESC) begin
            r.st.esc = 1'b1;
        end else if (!b[7]) begin
            r.add = (b != 8'd0) ? 2'd1 : 2'd0;
        end else if (b[7:5] == 3'b110) begin
            r.st.pend   = 2'd1;
            r.st.seqlen = 2'd1;
            r.st.cp     = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            r.st.pend   = 2'd2;
            r.st.seqlen = 2'd2;
            r.st.cp     = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            r.st.pend   = 2'd3;
            r.st.seqlen = 2'd3;
            r.st.cp     = {18'd0, b[2:0]};
        end
        return r;
    endfunction

    // Saturating add of a small increment
    function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] c,
                                                      logic [3:0] a);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, c} + COUNT_W1'(a);
        return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/twvc_step.sv =====
// Input register and per-byte decoder with the running column count.
// Depends on twvc_pkg; feeds the end-of-string stage.
`default_nettype none

module twvc_step import twvc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_beat   i_in,
    output logic       o_in_ready,
    output logic       o_tail_valid,
    output t_tail_beat o_tail,
    input  logic       i_tail_ready
);

    logic                  r_in_valid;
    t_in_beat              r_in;
    t_dec_state            r_st;
    logic [7:0]            r_held0;
    logic [7:0]            r_held1;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_tail_valid;
    t_tail_beat            r_tail;

    t_step_res             step;
    logic [7:0]            n_held0;
    logic [7:0]            n_held1;
    logic [COUNT_BITS-1:0] n_count;
    logic                  tail_free;
    logic                  go;

    // Decode the registered byte
    always_comb begin
        step    = dec_consume(r_st, r_in.text_byte);
        n_held0 = (step.held_we && !step.held_idx) ? r_in.text_byte : r_held0;
        n_held1 = (step.held_we &&  step.held_idx) ? r_in.text_byte : r_held1;
        n_count = sat_add(r_count, {2'b00, step.add});
    end

    // Handshake: a last byte waits for room in the tail register
    assign tail_free  = !r_tail_valid || i_tail_ready;
    assign go         = r_in_valid && (!r_in.is_last || tail_free);
    assign o_in_ready = !r_in_valid || go;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_tail_valid <= 1'b0;
            r_st         <= '0;
            r_count      <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go && r_in.is_last) begin
                r_tail_valid <= 1'b1;
            end else if (i_tail_ready) begin
                r_tail_valid <= 1'b0;
            end
            if (go) begin
                // end of string returns the decoder to its reset state
                r_st    <= r_in.is_last ? '0 : step.st;
                r_count <= r_in.is_last ? '0 : n_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (go) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
        if (go && r_in.is_last) begin
            r_tail.st    <= step.st;
            r_tail.held0 <= n_held0;
            r_tail.held1 <= n_held1;
            r_tail.count <= n_count;
        end
    end

    assign o_tail_valid = r_tail_valid;
    assign o_tail       = r_tail;

endmodule

`default_nettype wire

// ===== rtl/twvc_tail.sv =====
// End-of-string stage: rescans held bytes of an unfinished sequence,
// adds their width and drives the result register. Depends on twvc_pkg.
`default_nettype none

module twvc_tail import twvc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tail_valid,
    input  t_tail_beat i_tail,
    output logic       o_tail_ready,
    output logic       o_out_valid,
    output t_out_beat  o_out,
    input  logic       i_out_ready
);

    logic                  r_out_valid;
    t_out_beat             r_out;
    logic [3:0]            extra;
    logic [COUNT_BITS-1:0] final_count;
    logic [31:0]           count_ext;

    // Drop the lead of an unfinished sequence and rescan what it held.
    // Two passes suffice: each pass leaves at least one fewer held byte.
    function automatic logic [3:0] rescan(t_dec_state s, logic [7:0] h0, logic [7:0] h1);
        t_dec_state st;
        t_step_res  r;
        logic [7:0] h [2];
        logic [7:0] c [2];
        logic [1:0] n;
        logic [3:0] sum;
        st   = s;
        h[0] = h0;
        h[1] = h1;
        sum  = 4'd0;
        for (int k = 0; k < 2; k++) begin
            if (st.pend != 2'd0) begin
                n = st.seqlen - st.pend;
                if (n > 2'd2) begin
                    n = 2'd2;
                end
                c         = h;
                st.pend   = 2'd0;
                st.seqlen = 2'd0;
                st.cp     = '0;
                for (int i = 0; i < 2; i++) begin
                    if (2'(i) < n) begin
                        r   = dec_consume(st, c[i]);
                        st  = r.st;
                        sum = sum + {2'b00, r.add};
                        if (r.held_we) begin
                            h[r.held_idx] = c[i];
                        end
                    end
                end
            end
        end
        return sum;
    endfunction

    always_comb begin
        extra       = rescan(i_tail.st, i_tail.held0, i_tail.held1);
        final_count = sat_add(i_tail.count, extra);
        count_ext   = 32'(final_count);
    end

    assign o_tail_ready = !r_out_valid || i_out_ready;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_tail_ready) begin
            r_out_valid <= i_tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tail_valid && o_tail_ready) begin
            r_out.display_width   <= count_ext[15:0];
            r_out.width_saturated <= (final_count == {COUNT_BITS{1'b1}});
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== rtl/terminal_visual_width_counter_unit.sv =====
// A string's last byte enters the input register, then the tail register, then the result register.
// Throughput: one byte per cycle unless a last byte waits for room in the tail register.
// A string's width is delivered once, on its last byte; the count then restarts at zero.
// Reset (synchronous, active low) empties all stages and clears decode state and count.
// Top level of the display-width counter; depends on twvc_pkg, twvc_step,
// twvc_tail and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module terminal_visual_width_counter_unit import twvc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_out_beat o_out,
    input  logic      i_out_ready
);

    logic       tail_valid;
    logic       tail_ready;
    t_tail_beat tail;

    // Per-byte decode and running count
    twvc_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in         (i_in),
        .o_in_ready   (o_in_ready),
        .o_tail_valid (tail_valid),
        .o_tail       (tail),
        .i_tail_ready (tail_ready)
    );

    // End-of-string fix-up and result register
    twvc_tail u_tail (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tail_valid (tail_valid),
        .i_tail       (tail),
        .o_tail_ready (tail_ready),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_ready  (i_out_ready)
    );

    // An unfinished sequence can never coexist with an open escape
    `ASSERT_ALWAYS(a_pend_no_esc, i_clk, i_rst_n, !tail_valid || tail.st.pend == 2'd0 || !tail.st.esc, "pending sequence with escape open")
    // Bytes still awaited never exceed the length the lead asked for
    `ASSERT_ALWAYS(a_pend_le_len, i_clk, i_rst_n, !tail_valid || tail.st.seqlen >= tail.st.pend, "pending count above sequence length")
    // A snapshot taken by the tail stage shows up as a result next cycle
    `ASSERT_NEXT(a_tail_to_out, i_clk, i_rst_n, tail_valid && tail_ready, o_out_valid, "tail beat lost")

endmodule

`default_nettype wire

// ===== dv/terminal_visual_width_counter_unit_tb.sv =====
// Self-checking bench for terminal_visual_width_counter_unit: byte strings go in, one
// display width per string comes out and is scored against a bench-side width predictor.
// Depends on twvc_pkg (beat types, COUNT_BITS) and the RTL of the block.
module terminal_visual_width_counter_unit_tb;
    import twvc_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          RANDOM_BYTES = 1100;
    localparam int          LONG_HOLD    = 400;
    localparam int          WIDE_COUNT   = 27;
    localparam longint      WIDTH_MAX    = (64'd1 << COUNT_BITS) - 1;

    // Escape sequence bytes
    localparam bit [7:0] CH_ESC     = 8'h1B;
    localparam bit [7:0] CH_SGR_END = 8'h6D;
    localparam bit [7:0] CH_BSLASH  = 8'h5C;
    localparam bit [7:0] CH_BEL     = 8'h07;

    // East Asian wide codepoint ranges, inclusive
    localparam int unsigned WIDE_FROM [WIDE_COUNT] = '{
        'h1100, 'h2329, 'h2E80, 'h2F00, 'h2FF0, 'h3000, 'h3041, 'h3099, 'h3105,
        'h3131, 'h3190, 'h31C0, 'h31F0, 'h3200, 'h3300, 'h3400, 'h4E00, 'hA000,
        'hA490, 'hAC00, 'hF900, 'hFE10, 'hFE30, 'hFF00, 'hFFE0, 'h20000, 'h30000
    };
    localparam int unsigned WIDE_TO [WIDE_COUNT] = '{
        'h115F, 'h232A, 'h2EFF, 'h2FDF, 'h2FFF, 'h303E, 'h3096, 'h30FF, 'h312F,
        'h318E, 'h31BF, 'h31EF, 'h31FF, 'h32FF, 'h33FF, 'h4DBF, 'h9FFF, 'hA48F,
        'hA4CF, 'hD7A3, 'hFAFF, 'hFE19, 'hFE6F, 'hFF60, 'hFFE6, 'h2FFFD, 'h3FFFD
    };

    typedef struct {
        t_in_beat beat;
        int       gap;
        bit       drain_first;
    } t_feed_item;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      drv_valid = 1'b0;
    t_in_beat  drv_beat = '0;
    logic      rx_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out;

    t_feed_item byte_feed_q [$];
    t_out_beat  width_expect_q [$];
    bit [7:0]   str_bytes [$];

    // Predictor state
    bit          esc_open;
    int          cont_left;
    int          cont_total;
    bit [20:0]   cp_accum;
    bit [7:0]    cont_bytes [2];
    longint      col_total;

    // Driver / monitor bookkeeping
    t_feed_item  next_item;
    bit          have_next;
    int          gap_left;
    int          hold_left;
    int          steady_left;
    int unsigned rx_pick;
    bit          long_hold_done;
    int          results_seen;
    int          err_count;
    int          cycle_count;

    terminal_visual_width_counter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (drv_valid),
        .i_in        (drv_beat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_ready (rx_ready)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- width predictor ----------------

    function automatic int glyph_columns(bit [20:0] cp);
        if (cp == 21'd0) begin
            return 0;
        end
        for (int i = 0; i < WIDE_COUNT; i++) begin
            if (cp >= WIDE_FROM[i] && cp <= WIDE_TO[i]) begin
                return 2;
            end
        end
        return 1;
    endfunction

    function automatic void add_columns(int n);
        col_total = (col_total + n > WIDTH_MAX) ? WIDTH_MAX : col_total + n;
    endfunction

    function automatic void clear_decode();
        cont_left  = 0;
        cont_total = 0;
        cp_accum   = '0;
    endfunction

    function automatic void scan_byte(bit [7:0] b);
        int idx;
        if (cont_left != 0) begin
            // continuation: tag bits ignored, ESC is plain data here
            idx = cont_total - cont_left;
            if (idx < 2) begin
                cont_bytes[idx] = b;
            end
            cp_accum = {cp_accum[14:0], b[5:0]};
            cont_left--;
            if (cont_left == 0) begin
                add_columns(glyph_columns(cp_accum));
                clear_decode();
            end
        end else if (esc_open) begin
            if (b == CH_SGR_END || b == CH_BSLASH || b == CH_BEL) begin
                esc_open = 1'b0;
            end
        end else if (b == CH_ESC) begin
            esc_open = 1'b1;
        end else if (!b[7]) begin
            if (b != 8'd0) begin
                add_columns(1);
            end
        end else if (b[7:5] == 3'b110) begin
            cont_left  = 1;
            cont_total = 1;
            cp_accum   = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            cont_left  = 2;
            cont_total = 2;
            cp_accum   = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            cont_left  = 3;
            cont_total = 3;
            cp_accum   = {18'd0, b[2:0]};
        end
        // other leads (stray continuation, 0xF8 and up) are dropped
    endfunction

    // End of string: drop an unfinished lead and rescan what it held
    function automatic t_out_beat close_string();
        t_out_beat res;
        bit [7:0]  replay [2];
        int        n;
        while (cont_left != 0) begin
            n = cont_total - cont_left;
            if (n > 2) begin
                n = 2;
            end
            replay = cont_bytes;
            clear_decode();
            for (int i = 0; i < n; i++) begin
                scan_byte(replay[i]);
            end
        end
        res.display_width   = col_total[15:0];
        res.width_saturated = (col_total == WIDTH_MAX);
        esc_open  = 1'b0;
        clear_decode();
        col_total = 0;
        return res;
    endfunction

    function automatic void predict_beat(t_in_beat beat);
        t_out_beat res;
        scan_byte(beat.text_byte);
        if (beat.is_last) begin
            res            = close_string();
            width_expect_q = {width_expect_q, res};
        end
    endfunction

    // ---------------- stimulus helpers ----------------

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Append one byte to the string being built
    function automatic void put_byte(bit [7:0] b);
        str_bytes = {str_bytes, b};
    endfunction

    task automatic emit_string(input bit no_gaps, input bit drain_first);
        t_feed_item it;
        for (int i = 0; i < str_bytes.size(); i++) begin
            it.beat.text_byte = str_bytes[i];
            it.beat.is_last   = (i == str_bytes.size() - 1);
            it.gap            = no_gaps ? 0 : idle_len();
            it.drain_first    = drain_first && (i == 0);
            byte_feed_q       = {byte_feed_q, it};
        end
        str_bytes.delete();
    endtask

    // Encode cp as a len-byte sequence, keeping only the first keep bytes
    task automatic push_utf8(input int unsigned cp, input int len, input int keep);
        bit [7:0] cb;
        case (len)
            2: put_byte(8'hC0 | 8'((cp >> 6) & 'h1F));
            3: put_byte(8'hE0 | 8'((cp >> 12) & 'hF));
            default: put_byte(8'hF0 | 8'((cp >> 18) & 'h7));
        endcase
        for (int k = 0; k < len - 1 && k + 1 < keep; k++) begin
            cb = 8'((cp >> (6 * (len - 2 - k))) & 'h3F);
            // tag bits are not checked, so sometimes send junk there
            cb[7:6] = ($urandom_range(0, 99) < 12) ? 2'($urandom) : 2'b10;
            put_byte(cb);
        end
    endtask

    task automatic push_random_char(input bit truncate);
        int unsigned cp;
        int unsigned r;
        int          idx;
        int          len;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            // hug the edges of a wide range
            idx = $urandom_range(0, WIDE_COUNT - 1);
            case ($urandom_range(0, 4))
                0: cp = WIDE_FROM[idx] - 1;
                1: cp = WIDE_FROM[idx];
                2: cp = WIDE_TO[idx];
                3: cp = WIDE_TO[idx] + 1;
                default: cp = $urandom_range(WIDE_FROM[idx], WIDE_TO[idx]);
            endcase
            len = (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
            if (len < 4 && $urandom_range(0, 9) == 0) begin
                len++;
            end
        end else if (r < 60) begin
            // small values, overlong forms and encoded zero among them
            cp  = $urandom_range(0, 'h7F);
            len = $urandom_range(2, 4);
        end else begin
            len = $urandom_range(2, 4);
            cp  = $urandom & ((32'd1 << (5 * len + 1)) - 1);
        end
        push_utf8(cp, len, truncate ? $urandom_range(1, len - 1) : len);
    endtask

    task automatic push_token();
        int unsigned r;
        int          nbody;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            put_byte(($urandom_range(0, 49) == 0) ? 8'($urandom_range(0, 'h7F))
                                                  : 8'($urandom_range('h20, 'h7E)));
        end else if (r < 45) begin
            put_byte(CH_ESC);
            nbody = $urandom_range(0, 4);
            for (int i = 0; i < nbody; i++) begin
                put_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range('h30, 'h3B))
                                                     : 8'($urandom));
            end
            case ($urandom_range(0, 11))
                0: ;  // left open
                1, 2, 3: put_byte(CH_BSLASH);
                4, 5, 6: put_byte(CH_BEL);
                default: put_byte(CH_SGR_END);
            endcase
        end else if (r < 80) begin
            push_random_char(1'b0);
        end else begin
            put_byte(8'($urandom));
        end
    endtask

    // ---------------- sender ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            have_next = 1'b0;
            gap_left  = 0;
        end else begin
            if (drv_valid && o_in_ready) begin
                predict_beat(drv_beat);
            end
            if (!drv_valid || o_in_ready) begin
                if (!have_next && byte_feed_q.size() > 0) begin
                    next_item = byte_feed_q.pop_front();
                    have_next = 1'b1;
                    gap_left  = next_item.gap;
                end
                if (have_next && gap_left == 0 &&
                    !(next_item.drain_first && width_expect_q.size() != 0)) begin
                    drv_valid <= 1'b1;
                    drv_beat  <= next_item.beat;
                    have_next = 1'b0;
                end else begin
                    drv_valid <= 1'b0;
                    if (have_next && gap_left > 0) begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // ---------------- receiver and checker ----------------

    function automatic void report_mismatch(string what, t_out_beat want, t_out_beat got);
        err_count++;
        if (err_count <= 10) begin
            $display("[%0d] %s: expected width %0d sat %0b, got width %0d sat %0b",
                     cycle_count, what, want.display_width, want.width_saturated,
                     got.display_width, got.width_saturated);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            hold_left   = 0;
            steady_left = 0;
        end else begin
            if (o_out_valid && rx_ready) begin
                results_seen++;
                if (width_expect_q.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, o_out);
                end else if (o_out.display_width !== width_expect_q[0].display_width ||
                             o_out.width_saturated !== width_expect_q[0].width_saturated) begin
                    report_mismatch("width mismatch", width_expect_q.pop_front(), o_out);
                end else begin
                    void'(width_expect_q.pop_front());
                end
            end
            // one long hold-off so the pipe backs up into the input
            if (results_seen == 40 && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                steady_left    = 0;
            end
            if (hold_left == 0 && steady_left == 0) begin
                rx_pick = $urandom_range(0, 99);
                if (rx_pick < 8) begin
                    steady_left = $urandom_range(30, 150);
                end else if (rx_pick < 35) begin
                    hold_left = idle_len();
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_ready <= 1'b0;
            end else begin
                if (steady_left > 0) begin
                    steady_left--;
                end
                rx_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- test sequence ----------------

    initial begin
        int fed;
        int strings_made;
        int ntok;

        esc_open  = 1'b0;
        clear_decode();
        cont_bytes = '{8'h00, 8'h00};
        col_total = 0;

        // Directed strings
        str_bytes = '{8'h00};                                   // NUL only
        emit_string(1'b0, 1'b0);
        str_bytes = '{CH_ESC, 8'h41, CH_SGR_END, CH_ESC, CH_BSLASH, CH_ESC, CH_BEL, 8'h7F};
        emit_string(1'b0, 1'b0);                                // all three terminators
        str_bytes = '{8'hC0, 8'h80};                            // overlong zero
        emit_string(1'b0, 1'b0);
        str_bytes = '{8'hE4, 8'hB8, 8'h80};                     // wide 3-byte
        emit_string(1'b1, 1'b0);
        str_bytes = '{8'hF0, 8'hA0, 8'h80, 8'h80};              // wide 4-byte plane 2
        emit_string(1'b0, 1'b0);
        str_bytes = '{8'h80, 8'hFF, 8'hF8};                     // invalid leads
        emit_string(1'b0, 1'b0);
        str_bytes = '{8'hE4, 8'h41};                            // unfinished, rescan
        emit_string(1'b0, 1'b0);
        str_bytes = '{8'hF0, 8'hE4, 8'h41};                     // nested rescan
        emit_string(1'b1, 1'b0);
        str_bytes = '{8'hC2, CH_ESC};                           // ESC as continuation
        emit_string(1'b0, 1'b0);
        str_bytes = '{CH_ESC};                                  // escape open at end
        emit_string(1'b0, 1'b0);

        // Random strings of mostly well-formed tokens
        fed = 0;
        strings_made = 0;
        while (fed < RANDOM_BYTES) begin
            ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
            for (int t = 0; t < ntok; t++) begin
                push_token();
            end
            if ($urandom_range(0, 99) < 15) begin
                push_random_char(1'b1);
            end
            fed += str_bytes.size();
            emit_string($urandom_range(0, 3) == 0, strings_made % 60 == 0);
            strings_made++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_feed_q.size() != 0 || have_next || drv_valid) begin
            @(posedge i_clk);
        end
        while (width_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (err_count == 0 && width_expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
